FILE: rtl/atli_pkg.sv
// ----------------------------------------------------------------------------
// atli_pkg
// Shared types and constants of the angle table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package atli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int WEIGHT_BITS     = 30;
    // rows compared per scan stage
    localparam int SCAN_CHUNK      = 8;

    // Q3.28 angle constants
    localparam logic signed [32:0] PI_Q     = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q = 33'sd1686629713;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        RS_INSIDE = 2'd0,
        RS_BELOW  = 2'd1,
        RS_ABOVE  = 2'd2
    } t_range_status;

    typedef struct packed {
        logic vld;
        logic wr;
    } t_ctl;

    // For queries the angle slot carries the wrapped query angle.
    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] lift;
        logic signed [31:0] drag;
        logic signed [31:0] moment;
    } t_row;

    typedef struct packed {
        t_row row0;
        t_row row1;
    } t_pair;

    // scan results: interval found, and query against the first and last rows
    typedef struct packed {
        logic found;
        logic lt_first;
        logic le_first;
        logic gt_last;
        logic ge_last;
    } t_edge;

    typedef struct packed {
        logic signed [31:0] lift;
        logic signed [31:0] drag;
        logic signed [31:0] moment;
    } t_coef;

    typedef struct packed {
        t_range_status status;
        logic          use_c1;
        t_coef         c0;
        t_coef         c1;
    } t_aux;

endpackage

`default_nettype wire

FILE: rtl/angle_table_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// angle_table_linear_interpolator_core
// Piecewise linear lookup of lift, drag and moment over an angle table.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries write and query requests;
// a write loads one table row and yields no result, a query yields one
// result on the output channel (o_out_valid / i_out_ready). i_cfg_we loads
// the row count; write it only while the block is idle.
// Pipeline from accept to result: one wrap stage, one scan stage per eight
// rows, row fetch, span setup, 30 restoring divider stages for the weight,
// multiply, final add.
// Throughput: one request per cycle while the receiver does not stall.
// Rows must be written before a query reads them.
// Reset clears all valid bits and sets the row count to 2; table contents
// stay undefined until written.
// When the receiver stalls with a result pending, the whole pipeline holds
// and o_in_ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_table_linear_interpolator_core import atli_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_opcode,
    input  wire logic [5:0]         i_entry_index,
    input  wire logic signed [31:0] i_entry_angle,
    input  wire logic signed [31:0] i_entry_lift,
    input  wire logic signed [31:0] i_entry_drag,
    input  wire logic signed [31:0] i_entry_moment,
    input  wire logic signed [31:0] i_query_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_lift,
    output logic signed [31:0]      o_drag,
    output logic signed [31:0]      o_moment,
    output logic [1:0]              o_range_status,
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_wdata
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int NSCAN = (TABLE_DEPTH + SCAN_CHUNK - 1) / SCAN_CHUNK;

    logic adv;
    logic r_ov;

    assign adv        = !r_ov || i_out_ready;
    assign o_in_ready = adv;

    // ---------------- row count ----------------
    logic [AW-1:0] r_last;
    logic [AW-1:0] n_last;

    always_comb begin
        int cnt;
        cnt = int'(i_cfg_wdata);
        if (cnt < 2) begin
            cnt = 2;
        end
        if (cnt > TABLE_DEPTH) begin
            cnt = TABLE_DEPTH;
        end
        n_last = AW'(cnt - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= AW'(1);
        end else if (i_cfg_we) begin
            r_last <= n_last;
        end
    end

    // ---------------- stage 0: wrap, index fold ----------------
    logic [AW-1:0] idx_tab [64];

    for (genvar g = 0; g < 64; g++) begin : g_idx_tab
        assign idx_tab[g] = AW'(g % TABLE_DEPTH);
    end

    logic signed [32:0] qx;
    logic signed [32:0] qw;

    assign qx = 33'(i_query_angle);

    always_comb begin
        priority if (qx > PI_Q) begin
            qw = qx - TWO_PI_Q;
        end else if (qx < -PI_Q) begin
            qw = qx + TWO_PI_Q;
        end else begin
            qw = qx;
        end
    end

    t_ctl          s_ctl  [NSCAN+1];
    t_row          s_row  [NSCAN+1];
    logic [AW-1:0] s_idx  [NSCAN+1];
    t_edge         s_edge [NSCAN+1];
    logic [AW-1:0] s_pos  [NSCAN+1];

    t_ctl          r_s0_ctl;
    t_row          r_s0_row;
    logic [AW-1:0] r_s0_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (adv) begin
            r_s0_ctl.vld <= i_in_valid;
            r_s0_ctl.wr  <= (i_opcode == OP_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_row.angle  <= (i_opcode == OP_WRITE) ? i_entry_angle : qw[31:0];
            r_s0_row.lift   <= i_entry_lift;
            r_s0_row.drag   <= i_entry_drag;
            r_s0_row.moment <= i_entry_moment;
            r_s0_idx        <= idx_tab[i_entry_index];
        end
    end

    assign s_ctl[0]  = r_s0_ctl;
    assign s_row[0]  = r_s0_row;
    assign s_idx[0]  = r_s0_idx;
    assign s_edge[0] = '0;
    assign s_pos[0]  = '0;

    // ---------------- scan: one stage per chunk of rows ----------------
    for (genvar k = 0; k < NSCAN; k++) begin : g_srch
        atli_srch_stage #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .BASE        (k * SCAN_CHUNK)
        ) u_srch (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_last  (r_last),
            .i_ctl   (s_ctl[k]),
            .i_row   (s_row[k]),
            .i_idx   (s_idx[k]),
            .i_edge  (s_edge[k]),
            .i_pos   (s_pos[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_row   (s_row[k+1]),
            .o_idx   (s_idx[k+1]),
            .o_edge  (s_edge[k+1]),
            .o_pos   (s_pos[k+1])
        );
    end

    // ---------------- row fetch ----------------
    logic               f_vld;
    logic signed [31:0] f_q;
    t_pair              f_pair;
    t_edge              f_edge;

    atli_fetch #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_last  (r_last),
        .i_ctl   (s_ctl[NSCAN]),
        .i_row   (s_row[NSCAN]),
        .i_idx   (s_idx[NSCAN]),
        .i_edge  (s_edge[NSCAN]),
        .i_pos   (s_pos[NSCAN]),
        .o_vld   (f_vld),
        .o_q     (f_q),
        .o_pair  (f_pair),
        .o_edge  (f_edge)
    );

    // ---------------- span setup ----------------
    logic          use_c0;
    logic          use_c1;
    t_range_status stat;
    logic [32:0]   num;
    logic [32:0]   den;

    always_comb begin
        use_c0 = f_edge.le_first;
        use_c1 = !f_edge.le_first && f_edge.ge_last;
        priority if (f_edge.lt_first) begin
            stat = RS_BELOW;
        end else if (f_edge.gt_last) begin
            stat = RS_ABOVE;
        end else begin
            stat = RS_INSIDE;
        end
        // zero over a unit span gives weight zero, which returns the lower row
        num = use_c0 ? '0 : 33'(33'(f_q) - 33'(f_pair.row0.angle));
        den = use_c0 ? 33'd1 : 33'(33'(f_pair.row1.angle) - 33'(f_pair.row0.angle));
    end

    logic        d_vld [WEIGHT_BITS+1];
    t_aux        d_aux [WEIGHT_BITS+1];
    logic [32:0] d_den [WEIGHT_BITS+1];
    logic [32:0] d_rem [WEIGHT_BITS+1];
    logic [WEIGHT_BITS-1:0] d_quo [WEIGHT_BITS+1];

    logic        r_p_vld;
    t_aux        r_p_aux;
    logic [32:0] r_p_den;
    logic [32:0] r_p_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (adv) begin
            r_p_vld <= f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_aux.status    <= stat;
            r_p_aux.use_c1    <= use_c1;
            r_p_aux.c0.lift   <= f_pair.row0.lift;
            r_p_aux.c0.drag   <= f_pair.row0.drag;
            r_p_aux.c0.moment <= f_pair.row0.moment;
            r_p_aux.c1.lift   <= f_pair.row1.lift;
            r_p_aux.c1.drag   <= f_pair.row1.drag;
            r_p_aux.c1.moment <= f_pair.row1.moment;
            r_p_den           <= den;
            r_p_num           <= num;
        end
    end

    assign d_vld[0] = r_p_vld;
    assign d_aux[0] = r_p_aux;
    assign d_den[0] = r_p_den;
    assign d_rem[0] = r_p_num;
    assign d_quo[0] = '0;

    // ---------------- weight divider ----------------
    for (genvar b = 0; b < WEIGHT_BITS; b++) begin : g_div
        atli_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_vld   (d_vld[b]),
            .i_aux   (d_aux[b]),
            .i_den   (d_den[b]),
            .i_rem   (d_rem[b]),
            .i_quo   (d_quo[b]),
            .o_vld   (d_vld[b+1]),
            .o_aux   (d_aux[b+1]),
            .o_den   (d_den[b+1]),
            .o_rem   (d_rem[b+1]),
            .o_quo   (d_quo[b+1])
        );
    end

    // ---------------- multiply ----------------
    logic signed [WEIGHT_BITS:0] wgt;
    logic signed [32:0]          dl;
    logic signed [32:0]          dd;
    logic signed [32:0]          dm;
    t_aux                        m_aux;

    assign m_aux = d_aux[WEIGHT_BITS];
    assign wgt   = {1'b0, d_quo[WEIGHT_BITS]};
    assign dl    = 33'(m_aux.c1.lift)   - 33'(m_aux.c0.lift);
    assign dd    = 33'(m_aux.c1.drag)   - 33'(m_aux.c0.drag);
    assign dm    = 33'(m_aux.c1.moment) - 33'(m_aux.c0.moment);

    logic               r_m_vld;
    t_aux               r_m_aux;
    logic signed [63:0] r_m_pl;
    logic signed [63:0] r_m_pd;
    logic signed [63:0] r_m_pm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (adv) begin
            r_m_vld <= d_vld[WEIGHT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_aux <= m_aux;
            r_m_pl  <= dl * wgt;
            r_m_pd  <= dd * wgt;
            r_m_pm  <= dm * wgt;
        end
    end

    // ---------------- round, add, output register ----------------
    // floor((p + 2^29) / 2^30): the rounding carry is bit 29 of p
    logic signed [31:0] il;
    logic signed [31:0] id;
    logic signed [31:0] im;

    assign il = r_m_aux.c0.lift   + r_m_pl[61:30] + {31'd0, r_m_pl[29]};
    assign id = r_m_aux.c0.drag   + r_m_pd[61:30] + {31'd0, r_m_pd[29]};
    assign im = r_m_aux.c0.moment + r_m_pm[61:30] + {31'd0, r_m_pm[29]};

    logic signed [31:0] r_o_lift;
    logic signed [31:0] r_o_drag;
    logic signed [31:0] r_o_moment;
    t_range_status      r_o_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_lift   <= r_m_aux.use_c1 ? r_m_aux.c1.lift   : il;
            r_o_drag   <= r_m_aux.use_c1 ? r_m_aux.c1.drag   : id;
            r_o_moment <= r_m_aux.use_c1 ? r_m_aux.c1.moment : im;
            r_o_stat   <= r_m_aux.status;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_lift         = r_o_lift;
    assign o_drag         = r_o_drag;
    assign o_moment       = r_o_moment;
    assign o_range_status = r_o_stat;

    // ---------------- assertions ----------------
    a_last_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last != '0)
        else $error("row count below two");

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_upper_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_vld && r_p_aux.use_c1) |-> (r_p_aux.status != RS_BELOW))
        else $error("upper row selected for a below-range request");

endmodule

`default_nettype wire

FILE: rtl/atli_srch_stage.sv
// ----------------------------------------------------------------------------
// atli_srch_stage
// One chunk of the pipelined interval scan, with its own copy of its angles.
// ----------------------------------------------------------------------------
`default_nettype none

module atli_srch_stage import atli_pkg::*; #(
    parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int  BASE        = 0,
    localparam int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic [AW-1:0] i_last,
    input  wire t_ctl          i_ctl,
    input  wire t_row          i_row,
    input  wire logic [AW-1:0] i_idx,
    input  wire t_edge         i_edge,
    input  wire logic [AW-1:0] i_pos,
    output t_ctl               o_ctl,
    output t_row               o_row,
    output logic [AW-1:0]      o_idx,
    output t_edge              o_edge,
    output logic [AW-1:0]      o_pos
);

    logic signed [31:0] r_ang [SCAN_CHUNK];
    t_ctl               r_ctl;
    t_row               r_row;
    logic [AW-1:0]      r_idx;
    t_edge              r_edge;
    logic [AW-1:0]      r_pos;
    t_edge              n_edge;
    logic [AW-1:0]      n_pos;

    always_comb begin
        n_edge = i_edge;
        n_pos  = i_pos;
        for (int i = 0; i < SCAN_CHUNK; i++) begin
            if (BASE + i < TABLE_DEPTH) begin
                if (BASE + i == 0) begin
                    n_edge.lt_first = (i_row.angle < r_ang[i]);
                    n_edge.le_first = (i_row.angle <= r_ang[i]);
                end
                if (AW'(BASE + i) == i_last) begin
                    n_edge.gt_last = (i_row.angle > r_ang[i]);
                    n_edge.ge_last = (i_row.angle >= r_ang[i]);
                end
                // first row in use above the query; row 0 never counts
                if (!n_edge.found && BASE + i > 0 && AW'(BASE + i) <= i_last
                    && r_ang[i] > i_row.angle) begin
                    n_edge.found = 1'b1;
                    n_pos        = AW'(BASE + i - 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    // writes land in this copy as they pass, so later queries see them
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < SCAN_CHUNK; i++) begin
                if (i_ctl.vld && i_ctl.wr && BASE + i < TABLE_DEPTH
                    && i_idx == AW'(BASE + i)) begin
                    r_ang[i] <= i_row.angle;
                end
            end
            r_row  <= i_row;
            r_idx  <= i_idx;
            r_edge <= n_edge;
            r_pos  <= n_pos;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_row  = r_row;
    assign o_idx  = r_idx;
    assign o_edge = r_edge;
    assign o_pos  = r_pos;

endmodule

`default_nettype wire

FILE: rtl/atli_fetch.sv
// ----------------------------------------------------------------------------
// atli_fetch
// Row store; reads the two rows bracketing the query.
// ----------------------------------------------------------------------------
`default_nettype none

module atli_fetch import atli_pkg::*; #(
    parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic [AW-1:0] i_last,
    input  wire t_ctl          i_ctl,
    input  wire t_row          i_row,
    input  wire logic [AW-1:0] i_idx,
    input  wire t_edge         i_edge,
    input  wire logic [AW-1:0] i_pos,
    output logic               o_vld,
    output logic signed [31:0] o_q,
    output t_pair              o_pair,
    output t_edge              o_edge
);

    t_row               r_mem [TABLE_DEPTH];
    logic               r_vld;
    logic signed [31:0] r_q;
    t_pair              r_pair;
    t_edge              r_edge;
    logic [AW-1:0]      rd_lo;
    logic [AW-1:0]      rd_hi;

    // at or beyond an end the end row is read; row 0 as lower, last as upper
    always_comb begin
        priority if (i_edge.le_first) begin
            rd_lo = '0;
        end else if (i_edge.ge_last) begin
            rd_lo = i_last - AW'(1);
        end else begin
            rd_lo = i_pos;
        end
    end

    assign rd_hi = rd_lo + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_ctl.vld && !i_ctl.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_ctl.vld && i_ctl.wr) begin
                r_mem[i_idx] <= i_row;
            end
            r_pair.row0 <= r_mem[rd_lo];
            r_pair.row1 <= r_mem[rd_hi];
            r_q         <= i_row.angle;
            r_edge      <= i_edge;
        end
    end

    assign o_vld  = r_vld;
    assign o_q    = r_q;
    assign o_pair = r_pair;
    assign o_edge = r_edge;

endmodule

`default_nettype wire

FILE: rtl/atli_div_stage.sv
// ----------------------------------------------------------------------------
// atli_div_stage
// One restoring step of the weight divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atli_div_stage import atli_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_vld,
    input  wire t_aux                   i_aux,
    input  wire logic [32:0]            i_den,
    input  wire logic [32:0]            i_rem,
    input  wire logic [WEIGHT_BITS-1:0] i_quo,
    output logic                        o_vld,
    output t_aux                        o_aux,
    output logic [32:0]                 o_den,
    output logic [32:0]                 o_rem,
    output logic [WEIGHT_BITS-1:0]      o_quo
);

    logic                   r_vld;
    t_aux                   r_aux;
    logic [32:0]            r_den;
    logic [32:0]            r_rem;
    logic [WEIGHT_BITS-1:0] r_quo;
    logic [33:0]            dbl;
    logic [33:0]            diff;
    logic                   ge;

    assign dbl  = {i_rem, 1'b0};
    assign diff = dbl - {1'b0, i_den};
    assign ge   = (dbl >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_aux <= i_aux;
            r_den <= i_den;
            r_rem <= ge ? diff[32:0] : dbl[32:0];
            r_quo <= {i_quo[WEIGHT_BITS-2:0], ge};
        end
    end

    assign o_vld = r_vld;
    assign o_aux = r_aux;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

FILE: tb/atli_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atli_checker
// Watches both channels and the row count port, keeps its own copy of the
// table, predicts each query's coefficients and status, and compares them
// with the results in order.
// ----------------------------------------------------------------------------
module atli_checker import atli_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_opcode,
    input  logic [5:0]         i_entry_index,
    input  logic signed [31:0] i_entry_angle,
    input  logic signed [31:0] i_entry_lift,
    input  logic signed [31:0] i_entry_drag,
    input  logic signed [31:0] i_entry_moment,
    input  logic signed [31:0] i_query_angle,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_lift,
    input  logic signed [31:0] i_drag,
    input  logic signed [31:0] i_moment,
    input  logic [1:0]         i_range_status,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic signed [31:0] lift;
        logic signed [31:0] drag;
        logic signed [31:0] moment;
        t_range_status      status;
    } t_lookup;

    logic signed [31:0] row_angle  [TABLE_DEPTH_DEF];
    logic signed [31:0] row_lift   [TABLE_DEPTH_DEF];
    logic signed [31:0] row_drag   [TABLE_DEPTH_DEF];
    logic signed [31:0] row_moment [TABLE_DEPTH_DEF];
    logic [6:0]         row_count;
    t_lookup            lookups_due[$];
    int                 mismatch_cnt;

    // c0 + round((c1 - c0) * w / 2^30), halves rounded up
    function automatic logic signed [31:0] blend(input logic signed [31:0] c0,
                                                 input logic signed [31:0] c1,
                                                 input longint w);
        longint d;
        longint p;
        d = longint'(c1) - longint'(c0);
        p = d * w + (longint'(1) <<< (WEIGHT_BITS - 1));
        return 32'(longint'(c0) + (p >>> WEIGHT_BITS));
    endfunction

    function automatic t_lookup lookup(input logic signed [31:0] qin);
        t_lookup r;
        longint  q;
        longint  a0;
        longint  a1;
        longint  w;
        int      n;
        int      j;
        int      k;
        n = (row_count < 2) ? 2 : ((row_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                                 : int'(row_count));
        q = qin;
        if (q > longint'(PI_Q))
            q = q - longint'(TWO_PI_Q);
        else if (q < -longint'(PI_Q))
            q = q + longint'(TWO_PI_Q);
        a0 = row_angle[0];
        a1 = row_angle[n-1];
        if (q <= a0 || q >= a1) begin
            k = (q <= a0) ? 0 : n - 1;
            r.lift   = row_lift[k];
            r.drag   = row_drag[k];
            r.moment = row_moment[k];
            r.status = (q < a0) ? RS_BELOW : ((q > a1) ? RS_ABOVE : RS_INSIDE);
            return r;
        end
        j = n - 1;
        for (k = 1; k < n; k++) begin
            if (longint'(row_angle[k]) > q) begin
                j = k;
                break;
            end
        end
        a0 = row_angle[j-1];
        a1 = row_angle[j];
        if (a1 > a0 && q >= a0)
            w = longint'((64'(q - a0) << WEIGHT_BITS) / 64'(a1 - a0));
        else
            w = 0;
        if (w >= (longint'(1) <<< WEIGHT_BITS))
            w = (longint'(1) <<< WEIGHT_BITS) - 1;
        r.lift   = blend(row_lift[j-1], row_lift[j], w);
        r.drag   = blend(row_drag[j-1], row_drag[j], w);
        r.moment = blend(row_moment[j-1], row_moment[j], w);
        r.status = RS_INSIDE;
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        mismatch_cnt = 0;
        row_count    = 2;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            row_angle[i]  = '0;
            row_lift[i]   = '0;
            row_drag[i]   = '0;
            row_moment[i] = '0;
        end
    end

    assign o_pending = lookups_due.size();

    always @(posedge i_clk) begin
        t_lookup e;
        if (!i_rst_n) begin
            row_count = 2;
            lookups_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (lookups_due.size() == 0) begin
                    o_fail_count++;
                    if (mismatch_cnt++ < 10)
                        $display("%0t: result with no query pending: %0d %0d %0d st %0d",
                                 $time, i_lift, i_drag, i_moment, i_range_status);
                end else begin
                    e = lookups_due.pop_front();
                    if (i_lift !== e.lift || i_drag !== e.drag || i_moment !== e.moment
                        || i_range_status !== e.status) begin
                        o_fail_count++;
                        if (mismatch_cnt++ < 10)
                            $display({"%0t: mismatch exp %0d %0d %0d st %0d,",
                                      " got %0d %0d %0d st %0d"},
                                     $time, e.lift, e.drag, e.moment, e.status,
                                     i_lift, i_drag, i_moment, i_range_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == OP_WRITE) begin
                    row_angle[i_entry_index]  = i_entry_angle;
                    row_lift[i_entry_index]   = i_entry_lift;
                    row_drag[i_entry_index]   = i_entry_drag;
                    row_moment[i_entry_index] = i_entry_moment;
                end else begin
                    lookups_due = {lookups_due, lookup(i_query_angle)};
                end
            end
            if (i_cfg_we)
                row_count = i_cfg_wdata;
        end
    end

endmodule

FILE: tb/tb_angle_table_linear_interpolator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_angle_table_linear_interpolator_core
// Loads increasing angle tables under several row counts and fires wrapped,
// edge and random queries with random stalls on both sides; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_angle_table_linear_interpolator_core;
    import atli_pkg::*;

    localparam longint ANG_MIN = -64'sd2147483648;
    localparam longint ANG_MAX = 64'sd2147483647;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_opcode;
    logic [5:0]         i_entry_index;
    logic signed [31:0] i_entry_angle;
    logic signed [31:0] i_entry_lift;
    logic signed [31:0] i_entry_drag;
    logic signed [31:0] i_entry_moment;
    logic signed [31:0] i_query_angle;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_lift;
    logic signed [31:0] o_drag;
    logic signed [31:0] o_moment;
    logic [1:0]         o_range_status;
    logic               i_cfg_we;
    logic [6:0]         i_cfg_wdata;

    int     fail_count;
    int     pending;
    int     tx_idle_pct;
    int     rx_idle_pct;
    logic   want_hold;
    logic   hold_done;
    int     rows_used;
    longint tbl_angle [TABLE_DEPTH_DEF];

    angle_table_linear_interpolator_core dut (.*);

    atli_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_opcode(i_opcode), .i_entry_index(i_entry_index),
        .i_entry_angle(i_entry_angle), .i_entry_lift(i_entry_lift),
        .i_entry_drag(i_entry_drag), .i_entry_moment(i_entry_moment),
        .i_query_angle(i_query_angle),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_lift(o_lift), .i_drag(o_drag), .i_moment(o_moment),
        .i_range_status(o_range_status),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (want_hold && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // entered and left at a falling edge; valid is left high on return
    task automatic send(input logic op, input logic [5:0] idx, input logic [31:0] ang,
                        input logic [31:0] lf, input logic [31:0] dr,
                        input logic [31:0] mo, input logic [31:0] q);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_entry_index  <= idx;
        i_entry_angle  <= ang;
        i_entry_lift   <= lf;
        i_entry_drag   <= dr;
        i_entry_moment <= mo;
        i_query_angle  <= q;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic write_row(input int idx, input longint ang, input logic [31:0] lf,
                             input logic [31:0] dr, input logic [31:0] mo);
        tbl_angle[idx] = ang;
        send(OP_WRITE, 6'(idx), 32'(ang), lf, dr, mo, $urandom());
    endtask

    task automatic query(input longint q);
        send(OP_QUERY, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
             32'(q));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic set_rows(input logic [6:0] cnt);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        rows_used = (cnt < 2) ? 2 : ((cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cnt));
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // strictly increasing angles over a full, pi-bounded or tightly packed span
    task automatic load_table();
        longint lo;
        longint hi;
        longint step;
        longint a;
        case ($urandom_range(2))
            0: begin lo = ANG_MIN; hi = ANG_MAX; end
            1: begin lo = -longint'(PI_Q) + $urandom_range(1000000);
                     hi = longint'(PI_Q) - $urandom_range(1000000); end
            default: begin lo = longint'($signed($urandom())) / 2;
                           hi = lo + rows_used * $urandom_range(1, 4); end
        endcase
        step = (hi - lo) / (rows_used + 1);
        if (step < 1) step = 1;
        a = lo;
        for (int i = 0; i < rows_used; i++) begin
            write_row(i, a, rand_coef(), rand_coef(), rand_coef());
            a = a + 1 + longint'($urandom()) % step;
        end
    endtask

    task automatic random_query();
        int k;
        k = $urandom_range(rows_used - 1);
        case ($urandom_range(7))
            0, 1: query(longint'($signed($urandom())));
            2, 3: query(tbl_angle[k] + $signed($urandom_range(2)) - 1);
            4, 5: query(k + 1 < rows_used
                        ? tbl_angle[k] + longint'($urandom()) % (tbl_angle[k+1] - tbl_angle[k])
                        : tbl_angle[k]);
            6:    query(($urandom_range(1) ? longint'(PI_Q) : -longint'(PI_Q))
                        + $signed($urandom_range(2)) - 1);
            default: query($urandom_range(1) ? ANG_MAX : ANG_MIN);
        endcase
    endtask

    initial begin
        logic [6:0] counts [9] = '{7'd64, 7'd127, 7'd3, 7'd33, 7'd0, 7'd17, 7'd1, 7'd100, 7'd2};
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_WRITE;
        i_entry_index  = '0;
        i_entry_angle  = '0;
        i_entry_lift   = '0;
        i_entry_drag   = '0;
        i_entry_moment = '0;
        i_query_angle  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        want_hold      = 1'b0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rows_used      = 2;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // full-range two-row table: every query wraps inside it
        set_rows(7'd2);
        write_row(0, ANG_MIN, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        write_row(1, ANG_MAX, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        query(ANG_MIN);
        query(ANG_MAX);
        query(longint'(PI_Q));
        query(-longint'(PI_Q));
        query(longint'(PI_Q) + 1);
        query(-longint'(PI_Q) - 1);
        query(0);
        // row count zero falls back to two rows; ends at +-pi/2
        set_rows(7'd0);
        write_row(0, -421657428, 32'h0100_0000, 32'h0000_0001, 32'hff00_0000);
        write_row(1, 421657428, 32'hff00_0000, 32'h7fff_ffff, 32'h0100_0000);
        query(-421657428);
        query(421657428);
        query(-421657429);
        query(421657429);
        query(-421657427);
        query(1);
        query(ANG_MAX);

        for (int ph = 0; ph < 9; ph++) begin
            tx_idle_pct = (ph < 3) ? 13 : ((ph < 6) ? 60 : 0);
            rx_idle_pct = (ph < 3) ? 60 : ((ph < 6) ? 13 : 0);
            set_rows(counts[ph]);
            load_table();
            if (ph == 3) want_hold = 1'b1;
            for (int n = 0; n < 150; n++) begin
                // writes to rows past the ones in use never touch a lookup
                if (rows_used < TABLE_DEPTH_DEF && $urandom_range(9) == 0)
                    write_row($urandom_range(TABLE_DEPTH_DEF - 1, rows_used),
                              longint'($signed($urandom())), $urandom(), $urandom(),
                              $urandom());
                else
                    random_query();
            end
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
